FILE: sv/timeout_delta_queue_macros.svh
// Assertion macros shared by the timeout queue RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef TIMEOUT_DELTA_QUEUE_MACROS_SVH
`define TIMEOUT_DELTA_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define TDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define TDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tdq_pkg.sv
package tdq_pkg;

  // Fixed field widths of the channel words.
  localparam int ID_W      = 4;
  localparam int NUM_IDS   = 16;
  localparam int FUNC_W    = 2;
  localparam int IN_DLY_W  = 32;

  // Operation codes carried in the func field.
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  // Commands broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_DEC,
    OP_INSERT,
    OP_REMOVE,
    OP_SHIFT
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] new_id;
  } cell_cmd_t;

endpackage

FILE: sv/tdq_intf.sv
// Request channel: one word per tick, add or remove.
interface tdq_in_if;
  logic                          valid;
  logic                          ready;
  logic [tdq_pkg::FUNC_W-1:0]    func;
  logic [tdq_pkg::ID_W-1:0]      thread_id;
  logic [tdq_pkg::IN_DLY_W-1:0]  delay_ticks;

  modport source (output valid, output func, output thread_id, output delay_ticks,
                  input ready);
  modport sink (input valid, input func, input thread_id, input delay_ticks,
                output ready);
endinterface

// Expiry channel: one word per expired identifier.
interface tdq_out_if;
  logic                      valid;
  logic                      ready;
  logic [tdq_pkg::ID_W-1:0]  expired_id;
  logic                      last;

  modport source (output valid, output expired_id, output last, input ready);
  modport sink (input valid, input expired_id, input last, output ready);
endinterface

FILE: sv/tdq_cell.sv
// One list position: holds an identifier and its delta to the entry ahead.
// Cells load from their left neighbor on insert and from their right
// neighbor on remove or expiry.
module tdq_cell #(
  parameter int IDX   = 0,
  parameter int DW    = 32,
  parameter int CNT_W = 5
) (
  input  logic                          clk,
  input  tdq_pkg::cell_cmd_t            cmd,
  input  logic [CNT_W-1:0]              pos,
  input  logic [DW-1:0]                 new_delta,
  input  logic [tdq_pkg::ID_W-1:0]      left_id,
  input  logic [DW-1:0]                 left_delta,
  input  logic [tdq_pkg::ID_W-1:0]      right_id,
  input  logic [DW-1:0]                 right_delta,
  output logic [tdq_pkg::ID_W-1:0]      id_o,
  output logic [DW-1:0]                 delta_o
);

  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

  logic [tdq_pkg::ID_W-1:0] id_r;
  logic [DW-1:0]            delta_r;
  logic                     is_succ;

  // This cell follows the insert or remove position.
  assign is_succ = (IDX > 0) && (pos == CNT_W'(IDX - 1));

  always_ff @(posedge clk) begin
    case (cmd.op)
      tdq_pkg::OP_HOLD: begin
      end
      tdq_pkg::OP_DEC: begin
        if (IDX == 0 && delta_r != '0) begin
          delta_r <= delta_r - DW'(1);
        end
      end
      tdq_pkg::OP_INSERT: begin
        if (MY_POS == pos) begin
          id_r    <= cmd.new_id;
          delta_r <= new_delta;
        end else if (MY_POS > pos) begin
          id_r <= left_id;
          // The old entry at the insert position now follows the new one.
          if (is_succ) begin
            delta_r <= left_delta - new_delta;
          end else begin
            delta_r <= left_delta;
          end
        end
      end
      tdq_pkg::OP_REMOVE: begin
        if (MY_POS == pos) begin
          // Successor moves in and adds the removed entry's delta to its own.
          id_r    <= right_id;
          delta_r <= right_delta + delta_r;
        end else if (MY_POS > pos) begin
          id_r    <= right_id;
          delta_r <= right_delta;
        end
      end
      tdq_pkg::OP_SHIFT: begin
        id_r    <= right_id;
        delta_r <= right_delta;
      end
      default: begin
      end
    endcase
  end

  assign id_o    = id_r;
  assign delta_o = delta_r;

endmodule

FILE: sv/timeout_delta_queue.sv
// Channel | Port   | Dir | Word
// --------+--------+-----+-------------------------------------------
// request | in_ch  | in  | func, thread_id, delay_ticks
// expiry  | out_ch | out | expired_id, last
//
// Remove completes when accepted. Add searches the list in S_WALK, stepping one
// cell per cycle up to position P, where the new entry lands, then inserts it.
// Tick completes when accepted on an empty list and otherwise enters S_CHECK; each
// expired identifier passes S_CHECK and then S_EMIT, held there while out_ch stalls.
// One request is in flight at a time; in_ch.ready is high only when idle.
// rst_n is synchronous and empties the list; cell contents are not cleared.
`include "timeout_delta_queue_macros.svh"

module timeout_delta_queue #(
  parameter int ENTRIES    = 16,
  parameter int DELAY_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  tdq_in_if.sink           in_ch,
  tdq_out_if.source        out_ch
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int DW    = DELAY_BITS;
  localparam int ID_W  = tdq_pkg::ID_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t                       state_r;
  logic [CNT_W-1:0]             count_r;
  logic [tdq_pkg::NUM_IDS-1:0]  queued_r;
  logic [CNT_W-1:0]             pos_r;
  logic [DW-1:0]                rem_r;
  logic [ID_W-1:0]              nid_r;
  logic                         out_valid_r;
  logic [ID_W-1:0]              out_id_r;
  logic                         out_last_r;

  logic [ID_W-1:0]  cell_id    [ENTRIES];
  logic [DW-1:0]    cell_delta [ENTRIES];
  logic [ID_W-1:0]  left_id    [ENTRIES];
  logic [DW-1:0]    left_delta [ENTRIES];
  logic [ID_W-1:0]  right_id   [ENTRIES];
  logic [DW-1:0]    right_delta[ENTRIES];

  tdq_pkg::cell_cmd_t  cmd;
  logic [CNT_W-1:0]    cmd_pos;
  logic [CNT_W-1:0]    rm_pos;
  logic [DW-1:0]       walk_delta;
  logic                walk_stop;
  logic                in_fire;
  logic                head_due;

  assign in_fire = in_ch.valid && in_ch.ready;

  // Neighbor wiring along the chain; the ends see their own contents.
  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      left_id[k]     = (k == 0) ? cell_id[k] : cell_id[(k == 0) ? 0 : k - 1];
      left_delta[k]  = (k == 0) ? cell_delta[k] : cell_delta[(k == 0) ? 0 : k - 1];
      right_id[k]    = (k == ENTRIES - 1) ? cell_id[k]
                                          : cell_id[(k == ENTRIES - 1) ? k : k + 1];
      right_delta[k] = (k == ENTRIES - 1) ? cell_delta[k]
                                          : cell_delta[(k == ENTRIES - 1) ? k : k + 1];
    end
  end

  // Position of the identifier named by a remove request.
  always_comb begin
    rm_pos = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (cell_id[k] == in_ch.thread_id && CNT_W'(k) < count_r) begin
        rm_pos = CNT_W'(k);
      end
    end
  end

  // Insert search: stop at the list end or at the first larger delta.
  assign walk_delta = cell_delta[pos_r[IDX_W-1:0]];
  assign walk_stop  = (pos_r == count_r) || (rem_r < walk_delta);
  assign head_due   = (count_r != '0) && (cell_delta[0] == '0);

  // Command broadcast to the cells.
  always_comb begin
    cmd.op     = tdq_pkg::OP_HOLD;
    cmd.new_id = nid_r;
    cmd_pos    = pos_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.func == tdq_pkg::FUNC_TICK && count_r != '0) begin
            cmd.op = tdq_pkg::OP_DEC;
          end else if (in_ch.func == tdq_pkg::FUNC_REMOVE &&
                       queued_r[in_ch.thread_id]) begin
            cmd.op  = tdq_pkg::OP_REMOVE;
            cmd_pos = rm_pos;
          end
        end
      end
      S_WALK: begin
        if (walk_stop) begin
          cmd.op = tdq_pkg::OP_INSERT;
        end
      end
      S_CHECK: begin
        if (head_due) begin
          cmd.op = tdq_pkg::OP_SHIFT;
        end
      end
      default: begin
      end
    endcase
  end

  // The cell chain.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tdq_cell #(
      .IDX   (g),
      .DW    (DW),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .pos         (cmd_pos),
      .new_delta   (rem_r),
      .left_id     (left_id[g]),
      .left_delta  (left_delta[g]),
      .right_id    (right_id[g]),
      .right_delta (right_delta[g]),
      .id_o        (cell_id[g]),
      .delta_o     (cell_delta[g])
    );
  end

  // Sequencer with list bookkeeping and the output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      queued_r    <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_ch.func)
              tdq_pkg::FUNC_TICK: begin
                if (count_r != '0) begin
                  state_r <= S_CHECK;
                end
              end
              tdq_pkg::FUNC_ADD: begin
                if (!queued_r[in_ch.thread_id] && count_r != CNT_W'(ENTRIES)) begin
                  rem_r   <= in_ch.delay_ticks[DW-1:0];
                  nid_r   <= in_ch.thread_id;
                  pos_r   <= '0;
                  state_r <= S_WALK;
                end
              end
              tdq_pkg::FUNC_REMOVE: begin
                if (queued_r[in_ch.thread_id]) begin
                  queued_r[in_ch.thread_id] <= 1'b0;
                  count_r                   <= count_r - CNT_W'(1);
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_WALK: begin
          if (walk_stop) begin
            queued_r[nid_r] <= 1'b1;
            count_r         <= count_r + CNT_W'(1);
            state_r         <= S_IDLE;
          end else begin
            rem_r <= rem_r - walk_delta;
            pos_r <= pos_r + CNT_W'(1);
          end
        end
        S_CHECK: begin
          if (head_due) begin
            out_id_r            <= cell_id[0];
            out_last_r          <= (count_r == CNT_W'(1)) || (cell_delta[1] != '0);
            out_valid_r         <= 1'b1;
            queued_r[cell_id[0]] <= 1'b0;
            count_r             <= count_r - CNT_W'(1);
            state_r             <= S_EMIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            state_r     <= out_last_r ? S_IDLE : S_CHECK;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.expired_id = out_id_r;
  assign out_ch.last       = out_last_r;

  // Consistency checks on the list bookkeeping and the expiry handshake.
  `TDQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(ENTRIES),
                  "entry count overflow")
  `TDQ_ASSERT_NOW(a_queued_matches_count, 1'b1,
                  $countones(queued_r) == int'(count_r),
                  "queued flags disagree with entry count")
  `TDQ_ASSERT_NOW(a_walk_in_list, state_r == S_WALK, pos_r <= count_r,
                  "insert search ran past the list end")
  `TDQ_ASSERT_NOW(a_idle_no_pending, in_ch.ready, !out_valid_r,
                  "request taken while an expiry word is pending")
  `TDQ_ASSERT_NEXT(a_emit_clears, out_valid_r && out_ch.ready && out_last_r,
                   state_r == S_IDLE && !out_valid_r,
                   "last expiry word did not end the tick")

endmodule

FILE: test/tb.sv
module tb;

  localparam int FUNC_W = tdq_pkg::FUNC_W;
  localparam int ID_W = tdq_pkg::ID_W;
  localparam int NUM_IDS = tdq_pkg::NUM_IDS;
  localparam int LIST_DEPTH = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int TARGET_WORDS = 170;
  localparam int CALM_AFTER = 140;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // One expected word on the expiry channel.
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            last;
  } expiry_t;

  // Keeps its own copy of the delta list and predicts the expiry words.
  class expiry_scoreboard;
    logic [ID_W-1:0] list_id[$];
    logic [31:0]     list_delta[$];
    bit              listed[NUM_IDS];
    expiry_t         due[$];
    int errors;
    int words;
    int ticks;
    int adds;
    int removes;
    int expirations;
    int deepest;

    function void note_request(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                               logic [31:0] dly);
      int pos;
      int n;
      logic [31:0] rem;
      expiry_t word;
      words++;
      case (func)
        tdq_pkg::FUNC_TICK: begin
          if (list_id.size() == 0) return;
          if (list_delta[0] != 0) list_delta[0] = list_delta[0] - 1;
          n = 0;
          while (n < list_id.size() && list_delta[n] == 0) n++;
          for (int k = 0; k < n; k++) begin
            word.id = list_id[k];
            word.last = (k + 1 == n);
            due.push_back(word);
            listed[list_id[k]] = 1'b0;
          end
          repeat (n) begin
            void'(list_id.pop_front());
            void'(list_delta.pop_front());
          end
          expirations += n;
          ticks++;
        end
        tdq_pkg::FUNC_ADD: begin
          if (listed[id] || list_id.size() >= LIST_DEPTH) return;
          // Walk the list, spending the deltas of entries that expire no later.
          pos = 0;
          rem = dly;
          while (pos < list_id.size() && rem >= list_delta[pos]) begin
            rem = rem - list_delta[pos];
            pos++;
          end
          list_id.insert(pos, id);
          list_delta.insert(pos, rem);
          if (pos + 1 < list_id.size())
            list_delta[pos + 1] = list_delta[pos + 1] - rem;
          listed[id] = 1'b1;
          if (list_id.size() > deepest) deepest = list_id.size();
          adds++;
        end
        tdq_pkg::FUNC_REMOVE: begin
          if (!listed[id]) return;
          pos = 0;
          while (pos < list_id.size() && list_id[pos] != id) pos++;
          if (pos < list_id.size()) begin
            // The successor adds the delta of the dropped entry to its own.
            if (pos + 1 < list_id.size())
              list_delta[pos + 1] = list_delta[pos + 1] + list_delta[pos];
            list_id.delete(pos);
            list_delta.delete(pos);
          end
          listed[id] = 1'b0;
          removes++;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_expiry(logic [ID_W-1:0] id, logic last);
      expiry_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected expiry word, actual id %0d last %0d", $time, id, last);
        errors++;
        return;
      end
      want = due.pop_front();
      if (want.id !== id) begin
        $display("%0t: expired_id mismatch, expected %0d actual %0d", $time, want.id, id);
        errors++;
      end
      if (want.last !== last) begin
        $display("%0t: last mismatch, expected %0d actual %0d", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit calm = 1'b0;
  int ready_hold = 0;
  int quiet_cycles = 0;
  expiry_scoreboard sb = new();

  tdq_in_if req_if();
  tdq_out_if exp_if();

  timeout_delta_queue #(
    .ENTRIES(LIST_DEPTH),
    .DELAY_BITS(32)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(req_if),
    .out_ch(exp_if)
  );

  // Clock with a period of 4.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The expiry sink stalls in short random bursts until the calm phase.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      exp_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(0, 4);
      exp_if.ready <= 1'b0;
    end else begin
      exp_if.ready <= 1'b1;
    end
  end

  // Both channels are observed at the rising edge; the watchdog runs here too.
  always @(posedge clk) begin
    if (rst_n) begin
      if (exp_if.valid && exp_if.ready)
        sb.check_expiry(exp_if.expired_id, exp_if.last);
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.func, req_if.thread_id, req_if.delay_ticks);
      if ((exp_if.valid && exp_if.ready) || (req_if.valid && req_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d expiries still due",
                 $time, STALL_LIMIT, sb.due.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Delays are mostly short so that entries expire, with wide values mixed in.
  function automatic logic [31:0] pick_delay();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 6);
      6, 7: return $urandom_range(0, 40);
      8: return $urandom;
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
    endcase
  endfunction

  // Sends one request word; it starts and ends at a falling edge.
  task automatic send_word(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                           logic [31:0] dly);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.func <= func;
    req_if.thread_id <= id;
    req_if.delay_ticks <= dly;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [ID_W-1:0] order[NUM_IDS];
    logic [ID_W-1:0] swap;
    int slot;
    int count;

    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.func = tdq_pkg::FUNC_TICK;
    req_if.thread_id = '0;
    req_if.delay_ticks = '0;
    exp_if.ready = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: ignored words, equal and zero delays, extremes, removes.
    send_word(tdq_pkg::FUNC_TICK, 4'd3, 32'd0);
    send_word(FUNC_UNUSED, 4'd15, 32'hFFFF_FFFF);
    send_word(tdq_pkg::FUNC_REMOVE, 4'd5, 32'd0);
    send_word(tdq_pkg::FUNC_ADD, 4'd0, 32'd0);
    send_word(tdq_pkg::FUNC_ADD, 4'd1, 32'd0);
    send_word(tdq_pkg::FUNC_ADD, 4'd2, 32'd1);
    send_word(tdq_pkg::FUNC_ADD, 4'd2, 32'd7);
    send_word(tdq_pkg::FUNC_ADD, 4'd15, 32'hFFFF_FFFF);
    send_word(tdq_pkg::FUNC_ADD, 4'd4, 32'd1);
    send_word(tdq_pkg::FUNC_REMOVE, 4'd2, 32'd0);
    send_word(tdq_pkg::FUNC_TICK, 4'd0, 32'd0);
    send_word(tdq_pkg::FUNC_TICK, 4'd0, 32'd0);
    send_word(tdq_pkg::FUNC_ADD, 4'd7, 32'h8000_0000);
    send_word(tdq_pkg::FUNC_ADD, 4'd8, 32'h5555_5555);
    send_word(tdq_pkg::FUNC_TICK, 4'd0, 32'd0);
    send_word(tdq_pkg::FUNC_REMOVE, 4'd15, 32'd0);
    send_word(tdq_pkg::FUNC_REMOVE, 4'd7, 32'd0);
    send_word(tdq_pkg::FUNC_REMOVE, 4'd8, 32'd0);
    send_word(tdq_pkg::FUNC_TICK, 4'd0, 32'd0);

    // Random part: mostly adds followed by ticks, with fills, removes and noise.
    while (sb.words < TARGET_WORDS) begin
      if (sb.words >= CALM_AFTER) calm = 1'b1;
      case ($urandom_range(0, 19))
        0: begin
          send_word(FUNC_W'($urandom_range(0, 3)), ID_W'($urandom_range(0, 15)),
                    $urandom);
        end
        1: begin
          // Fill the whole list in a shuffled order, then retry one id.
          for (int k = 0; k < NUM_IDS; k++) order[k] = ID_W'(k);
          for (int k = NUM_IDS - 1; k > 0; k--) begin
            slot = $urandom_range(0, k);
            swap = order[k];
            order[k] = order[slot];
            order[slot] = swap;
          end
          for (int k = 0; k < NUM_IDS; k++)
            send_word(tdq_pkg::FUNC_ADD, order[k], $urandom_range(0, 3));
          send_word(tdq_pkg::FUNC_ADD, order[0], $urandom_range(0, 3));
          repeat (5)
            send_word(tdq_pkg::FUNC_TICK, ID_W'($urandom_range(0, 15)), $urandom);
        end
        2, 3: begin
          repeat ($urandom_range(1, 3)) begin
            if (sb.list_id.size() > 0 && $urandom_range(0, 1)) begin
              slot = $urandom_range(0, sb.list_id.size() - 1);
              send_word(tdq_pkg::FUNC_REMOVE, sb.list_id[slot], $urandom);
            end else begin
              send_word(tdq_pkg::FUNC_REMOVE, ID_W'($urandom_range(0, 15)), $urandom);
            end
          end
        end
        default: begin
          count = $urandom_range(1, 5);
          repeat (count)
            send_word(tdq_pkg::FUNC_ADD, ID_W'($urandom_range(0, 15)), pick_delay());
          if (sb.list_id.size() > 12 || $urandom_range(0, 2) == 0) begin
            slot = $urandom_range(0, sb.list_id.size() - 1);
            send_word(tdq_pkg::FUNC_REMOVE, sb.list_id[slot], $urandom);
          end
          count = $urandom_range(1, 6);
          repeat (count)
            send_word(tdq_pkg::FUNC_TICK, ID_W'($urandom_range(0, 15)), $urandom);
        end
      endcase
    end
    req_if.valid <= 1'b0;

    // Let every predicted expiry arrive, then give the block time to settle.
    while (sb.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d request words: %0d ticks, %0d adds and %0d removes took effect.",
             sb.words, sb.ticks, sb.adds, sb.removes);
    $display("The list reached %0d entries; %0d expiries checked, %0d mismatches seen.",
             sb.deepest, sb.expirations, sb.errors);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/tdq_pkg.sv
sv/tdq_intf.sv
sv/tdq_cell.sv
sv/timeout_delta_queue.sv
test/tb.sv
